// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds request codes, character codes, cursor command codes and the cell record.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

  // Widths fixed by the port definition.
  localparam int IDX_W     = 11;
  localparam int CFG_AW    = 3;
  localparam int CFG_IDX_W = 1;

  // Request kinds carried by in_req_type.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Character codes with a control meaning.
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;

  // Attribute that the register holds after reset.
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // Configuration register index of the default attribute.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ATTR = 1'b0;

  // One stored cell.
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  // Cursor update commands.
  typedef logic [2:0] cur_cmd_t;
  localparam cur_cmd_t CUR_HOLD    = 3'd0;
  localparam cur_cmd_t CUR_ADVANCE = 3'd1;
  localparam cur_cmd_t CUR_NEWLINE = 3'd2;
  localparam cur_cmd_t CUR_BACK    = 3'd3;
  localparam cur_cmd_t CUR_TAB     = 3'd4;
  localparam cur_cmd_t CUR_PARK    = 3'd5;
  localparam cur_cmd_t CUR_HOME    = 3'd6;

  // Cursor advance for a tab.
  localparam int TAB_CELLS = 4;

endpackage

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: request sequencer, configuration port, output register.
// Depends on tcw_pkg, tcw_cell_mem and tcw_cursor.
//
//   channel   ports                         direction  moves
//   in_       in_valid / in_stall           into       one request per handshake
//   out_      out_valid / out_stall         out of     one result per request
//   APB       psel penable pwrite paddr ... into       default attribute register
//
// A put, read or unused request first acts on the cell store and the cursor, then loads
// the output register. A clear blanks every cell, and a request that scrolls copies the
// rows up and blanks the last row; the single write port of the cell store moves or
// blanks one cell per cycle through one shared address counter. After reset the block
// blanks the store and holds in_stall high; configuration writes are taken meanwhile.
// A stalled result stays in the output register, and a new request can be taken while
// it waits.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_char_code,
  input  logic [IDX_W-1:0]  in_cell_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_cursor_cell,
  output logic [7:0]        out_read_char,
  output logic [7:0]        out_read_attr,
  output logic              out_scrolled,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int SPAN  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 4);

  localparam logic [31:0] CELLS_W = 32'(CELLS);

  // Sequencer states.
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wa_r;
  logic [7:0]    attr_r;
  logic          scrolled_r, scrolled_nxt;
  logic          rd_hit_r, rd_hit_nxt;

  logic          out_valid_r;
  logic [IDX_W-1:0] out_cursor_r;
  logic [7:0]    out_char_r;
  logic [7:0]    out_attr_r;
  logic          out_scrolled_r;

  logic          accept;
  logic          in_range;
  logic          out_free;
  logic          out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;

  cur_cmd_t      cur_cmd;
  logic [CW-1:0] cur_cell;
  logic          scroll_due;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_range = (32'(in_cell_index) < CELLS_W);
  assign out_free = !out_valid_r || !out_stall;

  // Configuration port. Writes complete in the access phase; pready is tied high.
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1:2] == CFG_IDX_ATTR) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[CFG_AW-1:2] == CFG_IDX_ATTR)) begin
      attr_r <= pwdata[7:0];
    end
  end

  // Cursor command for this cycle. A put request steps the cursor and a clear sends it home
  // as it is taken; the copy phase of a scroll parks it at the start of the last row.
  always_comb begin
    cur_cmd = CUR_HOLD;
    if (accept) begin
      unique case (in_req_type)
        REQ_PUT: begin
          unique case (in_char_code)
            CHAR_NEWLINE:   cur_cmd = CUR_NEWLINE;
            CHAR_BACKSPACE: cur_cmd = CUR_BACK;
            CHAR_TAB:       cur_cmd = CUR_TAB;
            default:        cur_cmd = CUR_ADVANCE;
          endcase
        end
        REQ_CLEAR: cur_cmd = CUR_HOME;
        default:   cur_cmd = CUR_HOLD;
      endcase
    end else if (state_r == ST_COPY) begin
      cur_cmd = CUR_PARK;
    end
  end

  // Main sequencer. The counter cnt_r is the one address unit shared by the
  // reset sweep, the clear sweep, the row copy of a scroll and the blanking of
  // the last row.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scrolled_nxt = scrolled_r;
    rd_hit_nxt   = rd_hit_r;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = '{ch: CHAR_SPACE, attr: attr_r};
    mem_re       = 1'b0;
    mem_raddr    = AW'(in_cell_index);
    out_load     = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // The reset sweep uses the reset attribute, since a register write may
        // already have landed while the sweep runs.
        mem_we    = 1'b1;
        mem_wdata = '{ch: CHAR_SPACE, attr: ATTR_RESET};
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          scrolled_nxt = 1'b0;
          rd_hit_nxt   = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = ST_DONE;
          unique case (in_req_type)
            REQ_PUT: begin
              unique case (in_char_code) inside
                CHAR_NEWLINE, CHAR_TAB: begin
                end
                CHAR_BACKSPACE: begin
                  // Backspace at the home cell leaves the store alone.
                  mem_we    = (cur_cell != '0);
                  mem_waddr = AW'(cur_cell - CW'(1));
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(cur_cell);
                  mem_wdata = '{ch: in_char_code, attr: attr_r};
                end
              endcase
              if (scroll_due) begin
                scrolled_nxt = 1'b1;
                state_nxt    = ST_COPY;
              end
            end
            REQ_READ: begin
              mem_re     = in_range;
              rd_hit_nxt = in_range;
            end
            REQ_CLEAR: begin
              state_nxt = ST_BLANK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_COPY: begin
        // Read one row ahead, write the value in the following cycle at the address
        // that the counter held at the read.
        mem_re    = (cnt_r != AW'(SPAN));
        mem_raddr = cnt_r + AW'(COLUMNS);
        mem_we    = (cnt_r != '0);
        mem_waddr = wa_r;
        mem_wdata = mem_rdata;
        if (cnt_r == AW'(SPAN)) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      scrolled_r  <= 1'b0;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      scrolled_r <= scrolled_nxt;
      rd_hit_r   <= rd_hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and the delayed copy address carry no reset.
  always_ff @(posedge clk) begin
    wa_r <= cnt_r;
    if (out_load) begin
      out_cursor_r   <= IDX_W'(cur_cell);
      out_char_r     <= rd_hit_r ? mem_rdata.ch : 8'd0;
      out_attr_r     <= rd_hit_r ? mem_rdata.attr : 8'd0;
      out_scrolled_r <= scrolled_r;
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cursor_cell = out_cursor_r;
  assign out_read_char   = out_char_r;
  assign out_read_attr   = out_attr_r;
  assign out_scrolled    = out_scrolled_r;

  tcw_cell_mem #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tcw_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cur_cmd),
    .cell_no   (cur_cell),
    .scroll_due(scroll_due)
  );

endmodule

// ===== rtl/tcw_cell_mem.sv =====
// Cell store of the text console writer: one write port, one registered read port.
// Depends on tcw_pkg for the cell record.
module tcw_cell_mem import tcw_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcw_cursor.sv =====
// Cursor register of the text console writer, kept as cell number, row and column.
// Depends on tcw_pkg for the cursor command codes.
module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cur_cmd_t                           cmd,
  output logic [$clog2(COLUMNS*ROWS+4)-1:0]  cell_no,
  output logic                               scroll_due
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CW     = $clog2(CELLS + 4);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COL_SW = COL_W + 1;

  logic [CW-1:0]     cell_r, cell_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_SW-1:0] col_tab;

  assign col_tab = {1'b0, col_r} + COL_SW'(TAB_CELLS);

  always_comb begin
    cell_nxt = cell_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    unique case (cmd)
      CUR_ADVANCE: begin
        cell_nxt = cell_r + CW'(1);
        if (col_r == COL_W'(COLUMNS - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      CUR_NEWLINE: begin
        cell_nxt = cell_r - CW'(col_r) + CW'(COLUMNS);
        col_nxt  = '0;
        row_nxt  = row_r + ROW_W'(1);
      end
      CUR_BACK: begin
        if (cell_r != '0) begin
          cell_nxt = cell_r - CW'(1);
          if (col_r == '0) begin
            col_nxt = COL_W'(COLUMNS - 1);
            row_nxt = row_r - ROW_W'(1);
          end else begin
            col_nxt = col_r - COL_W'(1);
          end
        end
      end
      CUR_TAB: begin
        cell_nxt = cell_r + CW'(TAB_CELLS);
        // Columns are at least eight wide, so a tab wraps at most once.
        if (col_tab >= COL_SW'(COLUMNS)) begin
          col_nxt = COL_W'(col_tab - COL_SW'(COLUMNS));
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_tab[COL_W-1:0];
        end
      end
      CUR_PARK: begin
        cell_nxt = CW'(CELLS - COLUMNS);
        row_nxt  = ROW_W'(ROWS - 1);
        col_nxt  = '0;
      end
      CUR_HOME: begin
        cell_nxt = '0;
        row_nxt  = '0;
        col_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      cell_r <= cell_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign cell_no    = cell_r;
  assign scroll_due = (row_nxt >= ROW_W'(ROWS));

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, attached to the top level by bind.
// Depends on tcw_pkg and on the port list of text_console_writer.
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [IDX_W-1:0] out_cursor_cell,
  input logic [7:0]       out_read_char,
  input logic [7:0]       out_read_attr,
  input logic             out_scrolled
);

  localparam int          CELLS      = COLUMNS * ROWS;
  localparam logic [31:0] CELLS_W    = 32'(CELLS);
  localparam logic [IDX_W-1:0] PARK_CELL = IDX_W'(CELLS - COLUMNS);

  // One request at a time: taking a request closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another was in progress");

  // The reported cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_cell) < CELLS_W))
    else $error("cursor reported past the last cell");

  // A scroll parks the cursor at the start of the last row.
  a_scroll_parks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_cell == PARK_CELL)
    else $error("scroll left the cursor off the last row start");

  // A scrolling request is a put, which returns no cell contents.
  a_scroll_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_read_char == 8'd0 && out_read_attr == 8'd0)
    else $error("scrolling result carries read data");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_cell) &&
      $stable(out_read_char) && $stable(out_read_attr) && $stable(out_scrolled))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);
